// ===== sv/rbwt_pkg.sv =====
// ---------------------------------------------------------------------------
// rbwt_pkg
// Shared types and constants for the run-length inverse BWT decoder.
// ---------------------------------------------------------------------------
package rbwt_pkg;

   localparam int BLOCK_SIZE = 4096;
   localparam int ADDR_W     = $clog2(BLOCK_SIZE);
   localparam int LEN_W      = $clog2(BLOCK_SIZE + 1);
   localparam int SYM_N      = 256;
   localparam int SYM_W      = 8;

   localparam logic [7:0] ZERO_CHAR  = 8'd48;
   localparam logic [2:0] SKIP_RESET = 3'd3;

   localparam logic       CMD_LOAD  = 1'b0;
   localparam logic       CMD_FETCH = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] count_char;
      logic [7:0] symbol;
      logic       last_run;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== sv/rle_inverse_bwt_decoder.sv =====
// ---------------------------------------------------------------------------
// rle_inverse_bwt_decoder
// Run-length expansion into a last-column block, inverse BWT, byte fetch.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (valid/stall) carries one command word. A load word expands
//   count_char-48 copies of symbol into the block at one byte per cycle.
//   A load marked last_run then builds the first-column offsets (a count
//   read and an offset write per symbol) and walks the block back to front
//   through rank lookups to invert it.
//   A fetch word returns one rsp word: the next byte, or status 1 when
//   nothing is left. A load returns status 2 only when the block has
//   overflowed, otherwise nothing.
//   One command is worked at a time; req_stall is high while a command is
//   in progress or while a rsp word waits, and a stalled rsp word holds.
//   csr channel writes skip_leading, which sets the fetch start when inversion ends.
//   Reset is synchronous: block empty, counts zero, skip_leading = 3.
// ---------------------------------------------------------------------------
module rle_inverse_bwt_decoder
   import rbwt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [2:0] csr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LDRD = 4'd1;
   localparam logic [3:0] S_LDCT = 4'd2;
   localparam logic [3:0] S_LDEX = 4'd3;
   localparam logic [3:0] S_SWRD = 4'd4;
   localparam logic [3:0] S_SWWR = 4'd5;
   localparam logic [3:0] S_WKRD = 4'd6;
   localparam logic [3:0] S_WKDT = 4'd7;
   localparam logic [3:0] S_WKNX = 4'd8;
   localparam logic [3:0] S_FTRD = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]  fptr_ff, fptr_in;
   logic              rdy_ff, rdy_in;
   logic              ovf_ff, ovf_in;
   logic [2:0]        skip_ff;
   logic [7:0]        reps_ff, reps_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  rank_ff, rank_in;
   logic [SYM_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] wrank_ff, wrank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic                     clr_cnt;
   logic                     cnt_we, cnt_re;
   logic [SYM_W-1:0]         cnt_wa, cnt_ra;
   logic [LEN_W-1:0]         cnt_wd, cnt_rd;
   logic                     lc_we, lc_re;
   logic [ADDR_W-1:0]        lc_wa, lc_ra;
   logic [SYM_W+ADDR_W-1:0]  lc_wd, lc_rd;
   logic                     fp_we, fp_re;
   logic [SYM_W-1:0]         fp_wa, fp_ra;
   logic [LEN_W-1:0]         fp_wd, fp_rd;
   logic                     dc_we, dc_re;
   logic [ADDR_W-1:0]        dc_wa, dc_ra;
   logic [SYM_W-1:0]         dc_wd, dc_rd;
   logic                     req_acc;
   logic [LEN_W:0]           next_sum;
   logic [LEN_W-1:0]         fill_m1;

   // memories
   rbwt_cnt_mem u_cnt (
      .clock(clock), .reset(reset), .clear(clr_cnt),
      .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_en(cnt_re), .rd_addr(cnt_ra), .rd_data(cnt_rd)
   );

   rbwt_ram #(.WIDTH(SYM_W + ADDR_W), .DEPTH(BLOCK_SIZE)) u_lastcol (
      .clock(clock), .wr_en(lc_we), .wr_addr(lc_wa), .wr_data(lc_wd),
      .rd_en(lc_re), .rd_addr(lc_ra), .rd_data(lc_rd)
   );

   rbwt_ram #(.WIDTH(LEN_W), .DEPTH(SYM_N)) u_firstpos (
      .clock(clock), .wr_en(fp_we), .wr_addr(fp_wa), .wr_data(fp_wd),
      .rd_en(fp_re), .rd_addr(fp_ra), .rd_data(fp_rd)
   );

   rbwt_ram #(.WIDTH(SYM_W), .DEPTH(BLOCK_SIZE)) u_decoded (
      .clock(clock), .wr_en(dc_we), .wr_addr(dc_wa), .wr_data(dc_wd),
      .rd_en(dc_re), .rd_addr(dc_ra), .rd_data(dc_rd)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign fill_m1   = fill_ff - LEN_W'(1);
   assign next_sum  = {1'b0, fp_rd} + (LEN_W + 1)'(wrank_ff);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      fptr_in      = fptr_ff;
      rdy_in       = rdy_ff;
      ovf_in       = ovf_ff;
      reps_in      = reps_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      rank_in      = rank_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      wrank_in     = wrank_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      clr_cnt = 1'b0;
      cnt_we = 1'b0; cnt_wa = sym_ff; cnt_wd = rank_ff;
      cnt_re = 1'b0; cnt_ra = sym_ff;
      lc_we  = 1'b0; lc_wa = fill_ff[ADDR_W-1:0];
      lc_wd  = {sym_ff, rank_ff[ADDR_W-1:0]};
      lc_re  = 1'b0; lc_ra = row_ff;
      fp_we  = 1'b0; fp_wa = idx_ff; fp_wd = total_ff;
      fp_re  = 1'b0; fp_ra = lc_rd[SYM_W+ADDR_W-1:ADDR_W];
      dc_we  = 1'b0; dc_wa = pos_ff; dc_wd = lc_rd[SYM_W+ADDR_W-1:ADDR_W];
      dc_re  = 1'b0; dc_ra = fptr_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_data.cmd == CMD_LOAD) begin
                  if (rdy_ff) begin
                     clr_cnt = 1'b1;
                     fill_in = '0;
                     fptr_in = '0;
                     rdy_in  = 1'b0;
                     ovf_in  = 1'b0;
                  end
                  reps_in  = (req_data.count_char > ZERO_CHAR) ?
                             req_data.count_char - ZERO_CHAR : 8'd0;
                  sym_in   = req_data.symbol;
                  last_in  = req_data.last_run;
                  state_in = S_LDRD;
               end else if (!rdy_ff || fptr_ff >= fill_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{data_byte: 8'd0, last_byte: 1'b0, status: ST_EMPTY};
               end else begin
                  dc_re    = 1'b1;
                  state_in = S_FTRD;
               end
            end
         end
         S_LDRD: begin
            cnt_re   = 1'b1;
            state_in = S_LDCT;
         end
         S_LDCT: begin
            rank_in  = cnt_rd;
            state_in = S_LDEX;
         end
         // one byte of the run per cycle
         S_LDEX: begin
            if (reps_ff != 8'd0) begin
               reps_in = reps_ff - 8'd1;
               if (fill_ff < LEN_W'(BLOCK_SIZE)) begin
                  lc_we   = 1'b1;
                  rank_in = rank_ff + LEN_W'(1);
                  fill_in = fill_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               cnt_we = 1'b1;
               if (last_ff) begin
                  idx_in   = '0;
                  total_in = '0;
                  state_in = S_SWRD;
               end else begin
                  if (ovf_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{data_byte: 8'd0, last_byte: 1'b0, status: ST_OVF};
                  end
                  state_in = S_IDLE;
               end
            end
         end
         // prefix sum of counts into first-column offsets
         S_SWRD: begin
            cnt_re   = 1'b1;
            cnt_ra   = idx_ff;
            state_in = S_SWWR;
         end
         S_SWWR: begin
            fp_we    = 1'b1;
            total_in = total_ff + cnt_rd;
            idx_in   = idx_ff + SYM_W'(1);
            if (idx_ff == SYM_W'(SYM_N - 1)) begin
               if (fill_ff == '0) begin
                  fptr_in  = LEN_W'(skip_ff);
                  rdy_in   = 1'b1;
                  if (ovf_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{data_byte: 8'd0, last_byte: 1'b0, status: ST_OVF};
                  end
                  state_in = S_IDLE;
               end else begin
                  row_in   = '0;
                  pos_in   = fill_m1[ADDR_W-1:0];
                  state_in = S_WKRD;
               end
            end else begin
               state_in = S_SWRD;
            end
         end
         // inversion walk, back to front
         S_WKRD: begin
            lc_re    = 1'b1;
            state_in = S_WKDT;
         end
         S_WKDT: begin
            dc_we    = 1'b1;
            wrank_in = lc_rd[ADDR_W-1:0];
            if (pos_ff == '0) begin
               fptr_in  = LEN_W'(skip_ff);
               rdy_in   = 1'b1;
               if (ovf_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{data_byte: 8'd0, last_byte: 1'b0, status: ST_OVF};
               end
               state_in = S_IDLE;
            end else begin
               fp_re    = 1'b1;
               state_in = S_WKNX;
            end
         end
         S_WKNX: begin
            if (next_sum >= {1'b0, fill_ff}) begin
               row_in = fill_m1[ADDR_W-1:0];
            end else begin
               row_in = next_sum[ADDR_W-1:0];
            end
            pos_in   = pos_ff - ADDR_W'(1);
            state_in = S_WKRD;
         end
         S_FTRD: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{data_byte: dc_rd,
                       last_byte: (fptr_ff + LEN_W'(1)) == fill_ff,
                       status: ST_OK};
            fptr_in  = fptr_ff + LEN_W'(1);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         fptr_ff      <= '0;
         rdy_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         skip_ff      <= SKIP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         fptr_ff      <= fptr_in;
         rdy_ff       <= rdy_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            skip_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      reps_ff  <= reps_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      rank_ff  <= rank_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
      row_ff   <= row_in;
      pos_ff   <= pos_in;
      wrank_ff <= wrank_in;
      rsp_ff   <= rsp_in;
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(BLOCK_SIZE))
      else $error("fill length beyond block size");

   a_ok_needs_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_OK) |-> rdy_ff)
      else $error("byte delivered from a block that is not ready");

   a_walk_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WKRD) |-> ({1'b0, row_ff} < fill_ff))
      else $error("inversion row outside block");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("command taken while busy");

endmodule

// ===== sv/rbwt_ram.sv =====
// ---------------------------------------------------------------------------
// rbwt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rbwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/rbwt_cnt_mem.sv =====
// ---------------------------------------------------------------------------
// rbwt_cnt_mem
// Per-symbol occurrence counts with one valid bit per entry for fast clear.
// ---------------------------------------------------------------------------
module rbwt_cnt_mem
   import rbwt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             wr_en,
   input  logic [SYM_W-1:0] wr_addr,
   input  logic [LEN_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [SYM_W-1:0] rd_addr,
   output logic [LEN_W-1:0] rd_data
);

   logic [LEN_W-1:0] mem [SYM_N];
   logic [SYM_N-1:0] vld_ff;
   logic [LEN_W-1:0] raw_ff;
   logic             hit_ff;

   // valid bits, cleared at once
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
         hit_ff <= vld_ff[rd_addr];
      end
   end

   // entry not yet written reads as zero
   assign rd_data = hit_ff ? raw_ff : '0;

endmodule
